[hdl/cbtq_pkg.sv]
// ----------------------------------------------------------------------------
// cbtq_pkg
// Shared types and constants for the copula bound table query block.
// ----------------------------------------------------------------------------
package cbtq_pkg;

  localparam int MAX_ROWS_DEF = 16;
  localparam int MAX_COLS_DEF = 16;

  // Q1.16 value width and the code for 1.0.
  localparam int VAL_W = 17;
  localparam logic [VAL_W-1:0] ONE_Q16 = 17'd65536;

  // Width of the size registers and of the write index fields.
  localparam int CFG_W = 5;
  localparam int IDX_W = 4;

  // Signed working width of the shared adder; holds every candidate exactly.
  localparam int ACC_W = 20;

  // Configuration register indexes.
  localparam logic CFG_IDX_ROWS = 1'b0;
  localparam logic CFG_IDX_COLS = 1'b1;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROW_RD,
    ST_ROW_CMP,
    ST_COL_RD,
    ST_COL_CMP,
    ST_T_RD,
    ST_RM_RD,
    ST_CM_RD,
    ST_OP,
    ST_FIN,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [CFG_W-1:0] rows;
    logic [CFG_W-1:0] cols;
  } cfg_t;

  typedef struct packed {
    logic [VAL_W-1:0] lower;
    logic [VAL_W-1:0] upper;
    logic             not_found;
  } res_t;

endpackage

[hdl/cbtq_table_mem.sv]
// ----------------------------------------------------------------------------
// cbtq_table_mem
// Single write port, single read port table memory with registered read data.
// ----------------------------------------------------------------------------
module cbtq_table_mem #(
  parameter int DEPTH = cbtq_pkg::MAX_ROWS_DEF * cbtq_pkg::MAX_COLS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [AW-1:0]              waddr_i,
  input  logic [cbtq_pkg::VAL_W-1:0] wdata_i,
  input  logic [AW-1:0]              raddr_i,
  output logic [cbtq_pkg::VAL_W-1:0] rdata_o
);

  logic [cbtq_pkg::VAL_W-1:0] mem_q [DEPTH];
  logic [cbtq_pkg::VAL_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/cbtq_alu.sv]
// ----------------------------------------------------------------------------
// cbtq_alu
// Shared signed add/subtract unit used for every search compare and bound step.
// ----------------------------------------------------------------------------
module cbtq_alu (
  input  cbtq_pkg::alu_op_e                 op_i,
  input  logic signed [cbtq_pkg::ACC_W-1:0] a_i,
  input  logic signed [cbtq_pkg::ACC_W-1:0] b_i,
  output logic signed [cbtq_pkg::ACC_W-1:0] y_o
);

  always_comb begin
    case (op_i)
      cbtq_pkg::ALU_ADD: y_o = a_i + b_i;
      cbtq_pkg::ALU_SUB: y_o = a_i - b_i;
      default:           y_o = a_i - b_i;
    endcase
  end

endmodule

[hdl/cbtq_seq.sv]
// ----------------------------------------------------------------------------
// cbtq_seq
// Query sequencer: marginal searches, window walk and bound clamps, all through
// one shared adder and one table read port.
// ----------------------------------------------------------------------------
module cbtq_seq #(
  parameter int MAX_ROWS = cbtq_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = cbtq_pkg::MAX_COLS_DEF,
  parameter int AW       = $clog2(MAX_ROWS * MAX_COLS)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [cbtq_pkg::VAL_W-1:0] u_i,
  input  logic [cbtq_pkg::VAL_W-1:0] v_i,
  input  cbtq_pkg::cfg_t             cfg_i,
  output logic [AW-1:0]              mem_raddr_o,
  input  logic [cbtq_pkg::VAL_W-1:0] mem_rdata_i,
  input  logic                       out_free_i,
  output logic                       done_o,
  output cbtq_pkg::res_t             res_o,
  output logic                       busy_o
);

  localparam int RIW   = $clog2(MAX_ROWS);
  localparam int CIW   = $clog2(MAX_COLS);
  localparam int ACC_W = cbtq_pkg::ACC_W;
  localparam int VAL_W = cbtq_pkg::VAL_W;
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ONE_S   =
    $signed({{(ACC_W-VAL_W){1'b0}}, cbtq_pkg::ONE_Q16});

  function automatic logic [AW-1:0] cell_addr(input logic [RIW-1:0] r,
                                               input logic [CIW-1:0] c);
    return AW'(32'(r) * 32'(MAX_COLS) + 32'(c));
  endfunction

  function automatic logic signed [ACC_W-1:0] ext(input logic [VAL_W-1:0] x);
    return $signed({{(ACC_W-VAL_W){1'b0}}, x});
  endfunction

  function automatic logic [VAL_W-1:0] sat_one(input logic signed [ACC_W-1:0] x);
    logic [VAL_W-1:0] r;
    if (x < 0) begin
      r = '0;
    end else if (x > ONE_S) begin
      r = cbtq_pkg::ONE_Q16;
    end else begin
      r = x[VAL_W-1:0];
    end
    return r;
  endfunction

  cbtq_pkg::state_e state_q, state_d;
  logic [2:0]              step_q, step_d;
  logic [RIW-1:0]          ci_q, ci_d, i_lo_q, i_lo_d, i_hi_q, i_hi_d;
  logic [CIW-1:0]          cj_q, cj_d, j_lo_q, j_lo_d, j_hi_q, j_hi_d;
  logic [VAL_W-1:0]        u_q, u_d, v_q, v_d;
  logic [VAL_W-1:0]        t_q, t_d, rm_q, rm_d, cm_q, cm_d;
  logic signed [ACC_W-1:0] d1_q, d1_d, d2_q, d2_d, acc_q, acc_d;
  logic signed [ACC_W-1:0] lower_q, lower_d, upper_q, upper_d;
  logic                    nf_q, nf_d;

  logic [31:0]             nr_w, nc_w;
  logic [RIW-1:0]          nr_m1, nr_m2, row_lo, row_hi;
  logic [CIW-1:0]          nc_m1, nc_m2, col_lo, col_hi;
  cbtq_pkg::alu_op_e       alu_op;
  logic signed [ACC_W-1:0] alu_a, alu_b, alu_y;
  logic signed [ACC_W-1:0] d1_pos, d1_neg, d2_pos, d2_neg, fl_c, fu_c;

  cbtq_alu u_alu (
    .op_i (alu_op),
    .a_i  (alu_a),
    .b_i  (alu_b),
    .y_o  (alu_y)
  );

  // Register values out of range are used as the nearest legal size.
  always_comb begin
    if (cfg_i.rows < cbtq_pkg::CFG_W'(2)) begin
      nr_w = 32'd2;
    end else if (32'(cfg_i.rows) > 32'(MAX_ROWS)) begin
      nr_w = 32'(MAX_ROWS);
    end else begin
      nr_w = 32'(cfg_i.rows);
    end
    if (cfg_i.cols < cbtq_pkg::CFG_W'(2)) begin
      nc_w = 32'd2;
    end else if (32'(cfg_i.cols) > 32'(MAX_COLS)) begin
      nc_w = 32'(MAX_COLS);
    end else begin
      nc_w = 32'(cfg_i.cols);
    end
  end

  assign nr_m1 = RIW'(nr_w - 32'd1);
  assign nr_m2 = RIW'(nr_w - 32'd2);
  assign nc_m1 = CIW'(nc_w - 32'd1);
  assign nc_m2 = CIW'(nc_w - 32'd2);

  // Window around the hit index: at the last index only the one before it.
  always_comb begin
    if (ci_q == nr_m1) begin
      row_lo = nr_m2;
      row_hi = nr_m2;
    end else if (ci_q != '0) begin
      row_lo = ci_q - RIW'(1);
      row_hi = ci_q;
    end else begin
      row_lo = '0;
      row_hi = '0;
    end
    if (cj_q == nc_m1) begin
      col_lo = nc_m2;
      col_hi = nc_m2;
    end else if (cj_q != '0) begin
      col_lo = cj_q - CIW'(1);
      col_hi = cj_q;
    end else begin
      col_lo = '0;
      col_hi = '0;
    end
  end

  assign d1_pos = d1_q[ACC_W-1] ? '0 : d1_q;
  assign d1_neg = d1_q[ACC_W-1] ? -d1_q : '0;
  assign d2_pos = d2_q[ACC_W-1] ? '0 : d2_q;
  assign d2_neg = d2_q[ACC_W-1] ? -d2_q : '0;
  assign fl_c   = alu_y[ACC_W-1] ? '0 : alu_y;
  assign fu_c   = alu_y[ACC_W-1] ? ext(u_q) : ext(v_q);

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    ci_d        = ci_q;
    cj_d        = cj_q;
    i_lo_d      = i_lo_q;
    i_hi_d      = i_hi_q;
    j_lo_d      = j_lo_q;
    j_hi_d      = j_hi_q;
    u_d         = u_q;
    v_d         = v_q;
    t_d         = t_q;
    rm_d        = rm_q;
    cm_d        = cm_q;
    d1_d        = d1_q;
    d2_d        = d2_q;
    acc_d       = acc_q;
    lower_d     = lower_q;
    upper_d     = upper_q;
    nf_d        = nf_q;
    alu_op      = cbtq_pkg::ALU_SUB;
    alu_a       = '0;
    alu_b       = '0;
    mem_raddr_o = '0;
    done_o      = 1'b0;

    case (state_q)
      cbtq_pkg::ST_IDLE: begin
        if (start_i) begin
          u_d     = u_i;
          v_d     = v_i;
          ci_d    = '0;
          lower_d = ACC_MIN;
          upper_d = ACC_MAX;
          nf_d    = 1'b0;
          state_d = cbtq_pkg::ST_ROW_RD;
        end
      end
      cbtq_pkg::ST_ROW_RD: begin
        mem_raddr_o = cell_addr(ci_q, nc_m1);
        state_d     = cbtq_pkg::ST_ROW_CMP;
      end
      cbtq_pkg::ST_ROW_CMP: begin
        alu_a = ext(mem_rdata_i);
        alu_b = ext(u_q);
        if (!alu_y[ACC_W-1]) begin
          i_lo_d  = row_lo;
          i_hi_d  = row_hi;
          cj_d    = '0;
          state_d = cbtq_pkg::ST_COL_RD;
        end else if (ci_q == nr_m1) begin
          nf_d    = 1'b1;
          step_d  = '0;
          state_d = cbtq_pkg::ST_FIN;
        end else begin
          ci_d    = ci_q + RIW'(1);
          state_d = cbtq_pkg::ST_ROW_RD;
        end
      end
      cbtq_pkg::ST_COL_RD: begin
        mem_raddr_o = cell_addr(nr_m1, cj_q);
        state_d     = cbtq_pkg::ST_COL_CMP;
      end
      cbtq_pkg::ST_COL_CMP: begin
        alu_a = ext(mem_rdata_i);
        alu_b = ext(v_q);
        if (!alu_y[ACC_W-1]) begin
          j_lo_d  = col_lo;
          j_hi_d  = col_hi;
          ci_d    = i_lo_q;
          cj_d    = col_lo;
          state_d = cbtq_pkg::ST_T_RD;
        end else if (cj_q == nc_m1) begin
          nf_d    = 1'b1;
          step_d  = '0;
          state_d = cbtq_pkg::ST_FIN;
        end else begin
          cj_d    = cj_q + CIW'(1);
          state_d = cbtq_pkg::ST_COL_RD;
        end
      end
      cbtq_pkg::ST_T_RD: begin
        mem_raddr_o = cell_addr(ci_q, cj_q);
        state_d     = cbtq_pkg::ST_RM_RD;
      end
      cbtq_pkg::ST_RM_RD: begin
        t_d         = mem_rdata_i;
        mem_raddr_o = cell_addr(ci_q, nc_m1);
        state_d     = cbtq_pkg::ST_CM_RD;
      end
      cbtq_pkg::ST_CM_RD: begin
        rm_d        = mem_rdata_i;
        mem_raddr_o = cell_addr(nr_m1, cj_q);
        step_d      = '0;
        state_d     = cbtq_pkg::ST_OP;
      end
      cbtq_pkg::ST_OP: begin
        step_d = step_q + 3'd1;
        case (step_q)
          3'd0: begin
            cm_d  = mem_rdata_i;
            alu_a = ext(rm_q);
            alu_b = ext(u_q);
            d1_d  = alu_y;
          end
          3'd1: begin
            alu_a = ext(cm_q);
            alu_b = ext(v_q);
            d2_d  = alu_y;
          end
          3'd2: begin
            alu_a = ext(t_q);
            alu_b = d1_pos;
            acc_d = alu_y;
          end
          3'd3: begin
            alu_a = acc_q;
            alu_b = d2_pos;
            if (alu_y > lower_q) begin
              lower_d = alu_y;
            end
          end
          3'd4: begin
            alu_op = cbtq_pkg::ALU_ADD;
            alu_a  = ext(t_q);
            alu_b  = d1_neg;
            acc_d  = alu_y;
          end
          default: begin
            alu_op = cbtq_pkg::ALU_ADD;
            alu_a  = acc_q;
            alu_b  = d2_neg;
            if (alu_y < upper_q) begin
              upper_d = alu_y;
            end
            step_d = '0;
            if (cj_q != j_hi_q) begin
              cj_d    = cj_q + CIW'(1);
              state_d = cbtq_pkg::ST_T_RD;
            end else if (ci_q != i_hi_q) begin
              ci_d    = ci_q + RIW'(1);
              cj_d    = j_lo_q;
              state_d = cbtq_pkg::ST_T_RD;
            end else begin
              state_d = cbtq_pkg::ST_FIN;
            end
          end
        endcase
      end
      cbtq_pkg::ST_FIN: begin
        step_d = step_q + 3'd1;
        case (step_q)
          3'd0: begin
            alu_op = cbtq_pkg::ALU_ADD;
            alu_a  = ext(u_q);
            alu_b  = ext(v_q);
            acc_d  = alu_y;
          end
          3'd1: begin
            alu_a = acc_q;
            alu_b = ONE_S;
            if (fl_c > lower_q) begin
              lower_d = fl_c;
            end
          end
          default: begin
            alu_a = ext(u_q);
            alu_b = ext(v_q);
            if (fu_c < upper_q) begin
              upper_d = fu_c;
            end
            step_d  = '0;
            state_d = cbtq_pkg::ST_OUT;
          end
        endcase
      end
      cbtq_pkg::ST_OUT: begin
        done_o = 1'b1;
        if (out_free_i) begin
          state_d = cbtq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = cbtq_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cbtq_pkg::ST_IDLE;
      step_q  <= '0;
      ci_q    <= '0;
      cj_q    <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      ci_q    <= ci_d;
      cj_q    <= cj_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_lo_q  <= i_lo_d;
    i_hi_q  <= i_hi_d;
    j_lo_q  <= j_lo_d;
    j_hi_q  <= j_hi_d;
    u_q     <= u_d;
    v_q     <= v_d;
    t_q     <= t_d;
    rm_q    <= rm_d;
    cm_q    <= cm_d;
    d1_q    <= d1_d;
    d2_q    <= d2_d;
    acc_q   <= acc_d;
    lower_q <= lower_d;
    upper_q <= upper_d;
    nf_q    <= nf_d;
  end

  assign res_o.lower     = sat_one(lower_q);
  assign res_o.upper     = sat_one(upper_q);
  assign res_o.not_found = nf_q;
  assign busy_o          = (state_q != cbtq_pkg::ST_IDLE);

endmodule

[hdl/copula_bound_table_query_top.sv]
// ----------------------------------------------------------------------------
// copula_bound_table_query_top
// Cumulative probability table with Frechet-Hoeffding bound queries.
// ----------------------------------------------------------------------------
//   channel  | handshake                   | payload
//   ---------+-----------------------------+--------------------------------------
//   input    | in_valid_i / in_stall_o     | mode, row, col, entry_value, u, v
//   output   | out_valid_o / out_stall_i   | lower_bound, upper_bound, not_found
//   config   | cfg_we_i                    | cfg_index_i, cfg_data_i
//
// A write beat gives no result. A query beat is served through the single
// table read port and the shared adder, and the input stalls until it is done.
// Reset clears control state only; the table is undefined until written. A
// stalled result sits in the output register while the block takes the next
// beat; a second result waits in the sequencer until it drains.
module copula_bound_table_query_top #(
  parameter int MAX_ROWS = cbtq_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = cbtq_pkg::MAX_COLS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       mode_i,
  input  logic [cbtq_pkg::IDX_W-1:0] row_i,
  input  logic [cbtq_pkg::IDX_W-1:0] col_i,
  input  logic [cbtq_pkg::VAL_W-1:0] entry_value_i,
  input  logic [cbtq_pkg::VAL_W-1:0] u_i,
  input  logic [cbtq_pkg::VAL_W-1:0] v_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [cbtq_pkg::VAL_W-1:0] lower_bound_o,
  output logic [cbtq_pkg::VAL_W-1:0] upper_bound_o,
  output logic                       not_found_o,
  input  logic                       cfg_we_i,
  input  logic                       cfg_index_i,
  input  logic [cbtq_pkg::CFG_W-1:0] cfg_data_i
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);

  cbtq_pkg::cfg_t cfg_q, cfg_d;
  cbtq_pkg::res_t res, out_q;
  logic           out_valid_q;
  logic           busy, accept, start, done, out_free, we;
  logic [AW-1:0]  waddr, raddr;
  logic [cbtq_pkg::VAL_W-1:0] wdata, rdata;

  assign in_stall_o = busy;
  assign accept     = in_valid_i && !busy;
  assign start      = accept && mode_i;

  // Writes outside the physical table are dropped; values above one saturate.
  assign we    = accept && !mode_i && (32'(row_i) < 32'(MAX_ROWS))
                 && (32'(col_i) < 32'(MAX_COLS));
  assign waddr = AW'(32'(row_i) * 32'(MAX_COLS) + 32'(col_i));
  assign wdata = (entry_value_i > cbtq_pkg::ONE_Q16) ? cbtq_pkg::ONE_Q16
                                                     : entry_value_i;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        cbtq_pkg::CFG_IDX_ROWS: cfg_d.rows = cfg_data_i;
        cbtq_pkg::CFG_IDX_COLS: cfg_d.cols = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rows <= cbtq_pkg::CFG_W'(16);
      cfg_q.cols <= cbtq_pkg::CFG_W'(16);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  cbtq_table_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  cbtq_seq #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS),
    .AW       (AW)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .u_i         (u_i),
    .v_i         (v_i),
    .cfg_i       (cfg_q),
    .mem_raddr_o (raddr),
    .mem_rdata_i (rdata),
    .out_free_i  (out_free),
    .done_o      (done),
    .res_o       (res),
    .busy_o      (busy)
  );

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && done) begin
      out_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign lower_bound_o = out_q.lower;
  assign upper_bound_o = out_q.upper;
  assign not_found_o   = out_q.not_found;

endmodule

[hdl/cbtq_checker.sv]
// ----------------------------------------------------------------------------
// cbtq_checker
// Port-level checks for the copula bound table query block, bound to the top.
// ----------------------------------------------------------------------------
module cbtq_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic                       mode_i,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic [cbtq_pkg::VAL_W-1:0] lower_bound_o,
  input logic [cbtq_pkg::VAL_W-1:0] upper_bound_o,
  input logic                       not_found_o
);

  // A query beat occupies the block for at least the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && mode_i) |=> in_stall_o)
    else $error("query beat did not make the block busy");

  // A write beat never produces a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !mode_i && !out_valid_o) |=> !out_valid_o)
    else $error("write beat produced a result");

  // Both bounds are saturated to one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (lower_bound_o <= cbtq_pkg::ONE_Q16)
                    && (upper_bound_o <= cbtq_pkg::ONE_Q16))
    else $error("bound above one");

  // A stalled result beat holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o && $stable(lower_bound_o)
      && $stable(upper_bound_o) && $stable(not_found_o))
    else $error("stalled result beat changed");

endmodule

bind copula_bound_table_query_top cbtq_checker u_cbtq_checker (.*);
